// ===== design/gmf_pkg.sv =====
package gmf_pkg;

   localparam int DEF_MAX_RADIUS = 2;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int HEIGHT_CAP     = 1024;

   localparam int PIX_W       = 8;
   localparam int RAD_W       = 2;
   localparam int ROW_W       = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 2;

   localparam logic [PIX_W-1:0] PAD_VALUE = 8'd128;
   localparam logic [PIX_W-1:0] PIX_MIN   = 8'h00;
   localparam logic [PIX_W-1:0] PIX_MAX   = 8'hFF;

   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic [RAD_W-1:0]      RESET_RADIUS       = 2'd1;
   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_WIDTH  = 11'd640;
   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_HEIGHT = 11'd480;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam int RSP_FIFO_DEPTH = 8;

   typedef struct packed {
      logic             opcode;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] median;
      logic             frame_last;
   } rsp_type;

   // One raster step of the column store, issued by the sequencer.
   typedef struct packed {
      logic             step;
      logic             emit;
      logic             last;
      logic [PIX_W-1:0] pixel;
   } step_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

// ===== design/gmf_ctrl.sv =====
module gmf_ctrl
   import gmf_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int WW = $clog2(MAX_WIDTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_pop,
   output step_type               step_o,
   output logic [CW-1:0]          addr_o,
   output logic [ROW_W-1:0]       out_row_o,
   output logic [CW-1:0]          out_col_o,
   output logic [RAD_W-1:0]       radius_o,
   output logic [WW-1:0]          width_o,
   output logic [ROW_W-1:0]       height_o
);

   localparam int LAG_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
   localparam int GW      = $clog2(LAG_MAX + 1);
   localparam int EXT_W   = (WW > CSR_DATA_W) ? WW : CSR_DATA_W;
   localparam int CNT_W   = $clog2(RSP_FIFO_DEPTH + 1);

   logic [RAD_W-1:0]      radius_ff;
   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;
   logic [CW-1:0]         in_col_ff, in_col_in;
   logic [ROW_W-1:0]      in_row_ff, in_row_in;
   logic [CW-1:0]         out_col_ff, out_col_in;
   logic [ROW_W-1:0]      out_row_ff, out_row_in;
   logic [GW-1:0]         gap_ff, gap_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic [RAD_W-1:0] r_eff;
   logic [EXT_W-1:0] w_ext;
   logic [WW-1:0]    w_eff;
   logic [ROW_W-1:0] h_eff;
   logic [GW-1:0]    lag;
   logic             full, pad_step, accept, pix_step, flush_step, step, emit, last;
   logic             csr_hit, in_wrap, out_wrap;

   always_comb begin
      r_eff = (int'(radius_ff) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_ff;
      w_ext = EXT_W'(width_ff);
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (w_ext > EXT_W'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(w_ext);
      end
      if (height_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (height_ff > ROW_W'(HEIGHT_CAP)) begin
         h_eff = ROW_W'(HEIGHT_CAP);
      end else begin
         h_eff = height_ff;
      end
      // Radius is at most three, so R*W is two shifted copies of W.
      lag = (r_eff[0] ? GW'(w_eff) : '0) + (r_eff[1] ? GW'({w_eff, 1'b0}) : '0) + GW'(r_eff);
   end

   // Once every pixel of the frame is in, the sequencer keeps stepping on its own
   // until the newest strip is lag positions ahead of the next output.
   assign full       = (in_row_ff >= h_eff);
   assign pad_step   = full && (gap_ff < lag);
   assign req_ready  = !pad_step && (cnt_ff < CNT_W'(RSP_FIFO_DEPTH));
   assign accept     = req_valid && req_ready;
   assign pix_step   = accept && (req_data.opcode == OP_PIXEL) && !full;
   assign flush_step = accept && (req_data.opcode == OP_FLUSH) && full;
   assign step       = pix_step || flush_step || pad_step;
   assign emit       = (pix_step && (gap_ff >= lag)) || flush_step;
   assign out_wrap   = (WW'(out_col_ff) + WW'(1)) == w_eff;
   assign in_wrap    = (WW'(in_col_ff) + WW'(1)) == w_eff;
   assign last       = emit && out_wrap && (out_row_ff == h_eff - ROW_W'(1));
   assign csr_hit    = csr_we && (csr_index == REG_RADIUS || csr_index == REG_IMAGE_WIDTH ||
                                  csr_index == REG_IMAGE_HEIGHT);

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      gap_in     = gap_ff;
      if (csr_hit || last) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         gap_in     = '0;
      end else begin
         if (step) begin
            if (in_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
         end
         if (emit) begin
            if (out_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end else if (step) begin
            gap_in = gap_ff + GW'(1);
         end
      end
      cnt_in = cnt_ff + CNT_W'(emit) - CNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RESET_RADIUS;
         width_ff   <= RESET_IMAGE_WIDTH;
         height_ff  <= RESET_IMAGE_HEIGHT;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         gap_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_RADIUS:       radius_ff <= csr_wdata[RAD_W-1:0];
               REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         gap_ff     <= gap_in;
         cnt_ff     <= cnt_in;
      end
   end

   assign step_o.step  = step;
   assign step_o.emit  = emit;
   assign step_o.last  = last;
   assign step_o.pixel = pix_step ? req_data.pixel : PAD_VALUE;
   assign addr_o       = in_col_ff;
   assign out_row_o    = out_row_ff;
   assign out_col_o    = out_col_ff;
   assign radius_o     = r_eff;
   assign width_o      = w_eff;
   assign height_o     = h_eff;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RSP_FIFO_DEPTH))
      else $error("result credit count above queue depth");

   a_gap_bound: assert property (@(posedge clock) disable iff (reset)
      gap_ff <= lag)
      else $error("input runs ahead of output by more than the lag");

   a_emit_at_lag: assert property (@(posedge clock) disable iff (reset)
      emit |-> gap_ff == lag)
      else $error("result issued with window not aligned to the lag");

endmodule

// ===== design/gmf_window.sv =====
module gmf_window
   import gmf_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int S  = 2 * MAX_RADIUS + 1,
   localparam int N  = S * S
) (
   input  logic                 clock,
   input  logic                 reset,
   input  step_type             step_i,
   input  logic [CW-1:0]        addr_i,
   input  logic [ROW_W-1:0]     out_row_i,
   input  logic [CW-1:0]        out_col_i,
   input  logic [RAD_W-1:0]     radius_i,
   input  logic [WW-1:0]        width_i,
   input  logic [ROW_W-1:0]     height_i,
   output tag_type              tag_o,
   output logic [N*PIX_W-1:0]   cells_o
);

   // Each word holds one column of the rows above the current one, newest row lowest.
   localparam int WORD_W = 2 * MAX_RADIUS * PIX_W;

   logic [WORD_W-1:0] mem [MAX_WIDTH];
   logic [WORD_W-1:0] rd_ff;
   logic [WORD_W-1:0] last_wr_ff;
   logic [WORD_W-1:0] word;
   logic [WORD_W-1:0] wr_word;

   step_type         s1_ff;
   logic [CW-1:0]    s1_addr_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [CW-1:0]    s1_col_ff;
   logic             s1_fwd_ff;
   logic             fwd_in;

   logic [PIX_W-1:0] col   [S];
   logic [PIX_W-1:0] win_ff [S][S];

   logic signed [ROW_W+1:0] rr [S];
   logic signed [WW+1:0]    cc [S];
   logic [S-1:0]            row_ok_in, col_ok_in, in_sq_in;
   logic [S-1:0]            row_ok_ff, col_ok_ff, in_sq_ff;
   tag_type                 s2_tag_ff;

   // A step issued right behind a write to the same column reads stale data.
   assign fwd_in = step_i.step && s1_ff.step && (addr_i == s1_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff     <= '0;
         s2_tag_ff <= '0;
      end else begin
         s1_ff          <= step_i;
         s2_tag_ff.valid <= s1_ff.emit;
         s2_tag_ff.last  <= s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= addr_i;
      s1_row_ff  <= out_row_i;
      s1_col_ff  <= out_col_i;
      s1_fwd_ff  <= fwd_in;
      row_ok_ff  <= row_ok_in;
      col_ok_ff  <= col_ok_in;
      in_sq_ff   <= in_sq_in;
   end

   always_ff @(posedge clock) begin
      if (step_i.step) begin
         rd_ff <= mem[addr_i];
      end
      if (s1_ff.step) begin
         mem[s1_addr_ff] <= wr_word;
         last_wr_ff      <= wr_word;
      end
   end

   assign word    = s1_fwd_ff ? last_wr_ff : rd_ff;
   assign wr_word = {word[WORD_W-PIX_W-1:0], s1_ff.pixel};

   always_comb begin
      col[0] = s1_ff.pixel;
      for (int k = 1; k < S; k++) begin
         col[k] = word[(k-1)*PIX_W +: PIX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff.step) begin
         win_ff[0] <= col;
         for (int j = 1; j < S; j++) begin
            win_ff[j] <= win_ff[j-1];
         end
      end
   end

   // Strip entry k is row out_row+R-k; window column j is column out_col+R-j.
   always_comb begin
      for (int k = 0; k < S; k++) begin
         rr[k] = $signed((ROW_W+2)'(s1_row_ff)) + $signed((ROW_W+2)'(radius_i))
                 - $signed((ROW_W+2)'(k));
         cc[k] = $signed((WW+2)'(s1_col_ff)) + $signed((WW+2)'(radius_i))
                 - $signed((WW+2)'(k));
         in_sq_in[k]  = (k <= 2 * int'(radius_i));
         row_ok_in[k] = (rr[k] >= 0) && (rr[k] < $signed((ROW_W+2)'(height_i)));
         col_ok_in[k] = (cc[k] >= 0) && (cc[k] < $signed((WW+2)'(width_i)));
      end
   end

   // Cells outside the active square are split evenly between the extremes,
   // which leaves the middle rank of the whole set on the active median.
   always_comb begin
      for (int j = 0; j < S; j++) begin
         for (int k = 0; k < S; k++) begin
            if (in_sq_ff[j] && in_sq_ff[k]) begin
               cells_o[(j*S+k)*PIX_W +: PIX_W] = (row_ok_ff[k] && col_ok_ff[j]) ?
                                                 win_ff[j][k] : PAD_VALUE;
            end else begin
               cells_o[(j*S+k)*PIX_W +: PIX_W] = (((j + k) & 1) == 0) ? PIX_MIN : PIX_MAX;
            end
         end
      end
   end

   assign tag_o = s2_tag_ff;

endmodule

// ===== design/gmf_median.sv =====
module gmf_median
   import gmf_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   localparam int S = 2 * MAX_RADIUS + 1,
   localparam int N = S * S
) (
   input  logic               clock,
   input  logic               reset,
   input  tag_type            tag_i,
   input  logic [N*PIX_W-1:0] cells_i,
   output tag_type            tag_o,
   output logic [PIX_W-1:0]   median_o
);

   localparam int RB  = $clog2(N);
   localparam int MID = N / 2;

   logic [PIX_W-1:0] v [N];
   logic [N-1:0]     less [N];

   tag_type          a_tag_ff;
   logic [PIX_W-1:0] a_val_ff [N];
   logic [N-1:0]     a_less_ff [N];

   tag_type          b_tag_ff;
   logic [PIX_W-1:0] b_val_ff [N];
   logic [RB-1:0]    b_rank_ff [N];

   logic [N-1:0]     hit;

   // Rank of a cell is the count of cells ordered before it; equal values
   // are ordered by position so that ranks form a permutation.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         v[i] = cells_i[i*PIX_W +: PIX_W];
      end
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            less[i][j] = (j != i) && ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
      end else begin
         a_tag_ff <= tag_i;
         b_tag_ff <= a_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         a_val_ff[i]  <= v[i];
         a_less_ff[i] <= less[i];
         b_val_ff[i]  <= a_val_ff[i];
         b_rank_ff[i] <= RB'($countones(a_less_ff[i]));
      end
   end

   always_comb begin
      median_o = '0;
      for (int i = 0; i < N; i++) begin
         hit[i] = (b_rank_ff[i] == RB'(MID));
         if (hit[i]) begin
            median_o = median_o | b_val_ff[i];
         end
      end
   end

   assign tag_o = b_tag_ff;

   a_one_median: assert property (@(posedge clock) disable iff (reset)
      b_tag_ff.valid |-> $onehot(hit))
      else $error("median rank not held by exactly one cell");

endmodule

// ===== design/gmf_rsp_fifo.sv =====
module gmf_rsp_fifo
   import gmf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_i,
   input  rsp_type data_i,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PW    = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   rsp_type          store_ff [RSP_FIFO_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_i) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(RSP_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(RSP_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + CNT_W'(push_i) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         store_ff[wr_ptr_ff] <= data_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> count_ff < CNT_W'(RSP_FIFO_DEPTH))
      else $error("result queue written while full");

endmodule

// ===== design/grayscale_median_filter_unit.sv =====
// Streaming median filter for 8-bit grayscale images with a square window of
// radius 0 to MAX_RADIUS (register radius, saturating). Pixels enter in raster
// order, at most one transfer per clock, and each result transfer carries the
// median of the (2R+1)x(2R+1) window around one output pixel; positions outside
// the image count as 128. Results trail the input by R lines plus R pixels; after
// the last pixel of a frame, flush transfers (opcode 1) each drain one remaining
// result, the final one marked with frame_last, after which a new frame starts.
// Pixels sent after the last pixel but before the frame is drained are dropped,
// as are flush transfers at any other time. The sustained rate is one item per
// clock while credits remain: the column store is a single memory with one read
// and one write per cycle, and each item costs one read-modify-write of one
// column word, with a forward path when two consecutive items hit the same column
// (image width one). When the whole frame is shorter than the output lag, the
// block steps through padding on its own after the last pixel, with the request
// side held off. Each result passes the window and rank-network registers into
// the output queue. The input side keeps accepting while results wait, until the
// eight-entry result queue and its in-flight credits are used up. Any write to
// the three configuration registers restarts the frame; writes must be made only
// while the block is idle, which the block itself does not enforce. The line
// store holds no reset state and needs no clearing pass: entries from earlier
// frames fall outside the window by row position and are masked to 128.
module grayscale_median_filter_unit
   import gmf_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int S  = 2 * MAX_RADIUS + 1;
   localparam int N  = S * S;

   step_type           step;
   logic [CW-1:0]      addr;
   logic [ROW_W-1:0]   out_row;
   logic [CW-1:0]      out_col;
   logic [RAD_W-1:0]   radius;
   logic [WW-1:0]      width;
   logic [ROW_W-1:0]   height;
   tag_type            win_tag;
   logic [N*PIX_W-1:0] cells;
   tag_type            med_tag;
   logic [PIX_W-1:0]   median;
   rsp_type            result;
   logic               rsp_pop;

   // A result transfer returns one credit to the sequencer.
   assign rsp_pop = rsp_valid && rsp_ready;

   // Raster counters, configuration and the credit count; decides per clock
   // whether the column store steps and whether that step yields a result.
   gmf_ctrl #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_pop   (rsp_pop),
      .step_o    (step),
      .addr_o    (addr),
      .out_row_o (out_row),
      .out_col_o (out_col),
      .radius_o  (radius),
      .width_o   (width),
      .height_o  (height)
   );

   // Column store memory and the window shift registers, with border masking.
   gmf_window #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .step_i    (step),
      .addr_i    (addr),
      .out_row_i (out_row),
      .out_col_i (out_col),
      .radius_i  (radius),
      .width_i   (width),
      .height_i  (height),
      .tag_o     (win_tag),
      .cells_o   (cells)
   );

   // Two-stage rank network: pairwise compares, then counts, then selection.
   gmf_median #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_median (
      .clock    (clock),
      .reset    (reset),
      .tag_i    (win_tag),
      .cells_i  (cells),
      .tag_o    (med_tag),
      .median_o (median)
   );

   assign result.median     = median;
   assign result.frame_last = med_tag.last;

   // Output queue decouples the fixed-latency pipeline from result stalls.
   gmf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_i    (med_tag.valid),
      .data_i    (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
